FILE: src/tmr_pkg.sv
// Package: sizes, slot and transaction types, op codes and states for the timer table.
`timescale 1ns / 1ps
package tmr_pkg;

   localparam int TaskSlots  = 16;
   localparam int MaxResults = 16;
   localparam int IdxW       = (TaskSlots > 1) ? $clog2(TaskSlots) : 1;
   localparam int FireCntW   = $clog2(MaxResults + 1);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(TaskSlots - 1);

   localparam logic [1:0] KindTick   = 2'd0;
   localparam logic [1:0] KindInsert = 2'd1;
   localparam logic [1:0] KindRemove = 2'd2;
   localparam logic [1:0] KindNone   = 2'd3;

   typedef enum logic [1:0] {
      OP_PASS,
      OP_INSERT,
      OP_REMOVE,
      OP_TICK
   } op_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         task_id;
      logic [30:0]        delay;
      logic signed [15:0] repeat_count;
      logic [30:0]        elapsed;
   } req_type;

   typedef struct packed {
      logic       fired;
      logic [7:0] fired_task;
      logic       status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]         task_id;
      logic [30:0]        remaining;
      logic [30:0]        reload;
      logic signed [15:0] repeats;
   } slot_type;

   typedef struct packed {
      op_mode_type        mode;
      logic               apply;
      logic [7:0]         task_id;
      logic [30:0]        delay;
      logic signed [15:0] repeat_count;
      logic [30:0]        elapsed;
   } op_type;

   typedef struct packed {
      logic match;
      logic free;
      logic fire;
   } slot_stat_type;

endpackage

FILE: src/multi_slot_periodic_timer.sv
// Top level: timer slot ring, head slot processor, sequencer and response register.
//
//   channel | ports                           | carries
//   req     | req_valid, req_stall, req_data  | tick / insert / remove transaction
//   rsp     | rsp_valid, rsp_stall, rsp_data  | fire or insert-status transaction
//
// The slots sit in a ring that rotates one slot per cycle past one slot processor while a
// transaction runs and no stall holds it. Tick and remove make one rotation, then a done
// state; insert makes a search rotation, then an update rotation; kind 3 makes none.
// A stalled response holds the ring only when a second fire needs the output, and
// holds the done cycle while the final response waits.
// Synchronous reset clears all slots at once; no clearing pass.
`timescale 1ns / 1ps
module multi_slot_periodic_timer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tmr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tmr_pkg::rsp_type rsp_data
);
   import tmr_pkg::*;

   state_type state_ff, state_in;
   logic [IdxW-1:0] cnt_ff, cnt_in, cnt_step;
   logic [FireCntW-1:0] fire_cnt_ff, fire_cnt_in;
   req_type req_ff, req_in;
   logic match_found_ff, match_found_in;
   logic [IdxW-1:0] match_idx_ff, match_idx_in;
   logic free_found_ff, free_found_in;
   logic [IdxW-1:0] free_idx_ff, free_idx_in;
   logic pend_valid_ff, pend_valid_in;
   rsp_type pend_ff, pend_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic req_accept;
   logic rsp_free;
   logic step_en;
   logic report;
   logic [IdxW-1:0] target;
   op_type op;
   slot_stat_type stat;
   slot_type head_next;
   slot_type cell_q [TaskSlots];

   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign cnt_step   = (cnt_ff == LastIdx) ? '0 : cnt_ff + 1'b1;
   assign target     = match_found_ff ? match_idx_ff : free_idx_ff;
   assign report     = stat.fire && (fire_cnt_ff < FireCntW'(MaxResults));

   for (genvar i = 0; i < TaskSlots; i++) begin : g_cell
      slot_type d;
      if (i == TaskSlots - 1) begin : g_tail
         assign d = head_next;
      end else begin : g_mid
         assign d = cell_q[i+1];
      end
      tmr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (step_en),
         .d        (d),
         .q        (cell_q[i])
      );
   end

   tmr_slot_op u_slot_op (
      .op       (op),
      .slot_in  (cell_q[0]),
      .slot_out (head_next),
      .stat     (stat)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_data.kind != KindNone)) begin
               state_in = (req_data.kind == KindInsert) ? ST_SCAN : ST_RUN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == LastIdx) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (step_en && (cnt_ff == LastIdx)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!pend_valid_ff || rsp_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      req_in         = req_ff;
      cnt_in         = cnt_ff;
      fire_cnt_in    = fire_cnt_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      pend_valid_in  = pend_valid_ff;
      pend_in        = pend_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      step_en        = 1'b0;

      op.mode         = OP_PASS;
      op.apply        = 1'b0;
      op.task_id      = req_ff.task_id;
      op.delay        = req_ff.delay;
      op.repeat_count = req_ff.repeat_count;
      op.elapsed      = req_ff.elapsed;

      if (state_ff == ST_RUN) begin
         unique case (req_ff.kind)
            KindTick: begin
               op.mode = OP_TICK;
            end
            KindInsert: begin
               op.mode  = OP_INSERT;
               op.apply = (match_found_ff || free_found_ff) && (cnt_ff == target);
            end
            KindRemove: begin
               op.mode  = OP_REMOVE;
               op.apply = !match_found_ff;
            end
            default: begin
               op.mode = OP_PASS;
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_in         = req_data;
               cnt_in         = '0;
               fire_cnt_in    = '0;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
            end
         end
         ST_SCAN: begin
            step_en = 1'b1;
            cnt_in  = cnt_step;
            if (stat.match && !match_found_ff) begin
               match_found_in = 1'b1;
               match_idx_in   = cnt_ff;
            end
            if (stat.free && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = cnt_ff;
            end
            if (cnt_ff == LastIdx) begin
               pend_valid_in      = 1'b1;
               pend_in.fired      = 1'b0;
               pend_in.fired_task = 8'd0;
               pend_in.status     = !(match_found_in || free_found_in);
               pend_in.last       = 1'b0;
            end
         end
         ST_RUN: begin
            step_en = !(report && pend_valid_ff && !rsp_free);
            if (step_en) begin
               cnt_in = cnt_step;
               if ((op.mode == OP_REMOVE) && stat.match) begin
                  match_found_in = 1'b1;
               end
               if (report) begin
                  fire_cnt_in = fire_cnt_ff + 1'b1;
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_ff;
                  end
                  pend_valid_in      = 1'b1;
                  pend_in.fired      = 1'b1;
                  pend_in.fired_task = cell_q[0].task_id;
                  pend_in.status     = 1'b0;
                  pend_in.last       = 1'b0;
               end
            end
         end
         ST_DONE: begin
            if (pend_valid_ff && rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         fire_cnt_ff    <= '0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         fire_cnt_ff    <= fire_cnt_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: src/tmr_cell.sv
// Ring cell: holds one timer slot and takes its neighbor's slot on each shift.
`timescale 1ns / 1ps
module tmr_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  tmr_pkg::slot_type d,
   output tmr_pkg::slot_type q
);
   import tmr_pkg::*;

   slot_type slot_ff;
   slot_type slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (shift_en) begin
         slot_in = d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign q = slot_ff;

endmodule

FILE: src/tmr_slot_op.sv
// Slot processor at the ring head: insert, remove and tick update of one slot.
`timescale 1ns / 1ps
module tmr_slot_op (
   input  tmr_pkg::op_type        op,
   input  tmr_pkg::slot_type      slot_in,
   output tmr_pkg::slot_type      slot_out,
   output tmr_pkg::slot_stat_type stat
);
   import tmr_pkg::*;

   logic               match;
   logic signed [15:0] rep_next;
   logic [30:0]        rem_diff;

   assign match    = (op.task_id != 8'd0) && (slot_in.task_id == op.task_id);
   assign rep_next = ((slot_in.repeats != 16'sd0) && !slot_in.repeats[15]) ?
                     slot_in.repeats - 16'sd1 : slot_in.repeats;
   assign rem_diff = slot_in.remaining - op.elapsed;

   always_comb begin
      slot_out   = slot_in;
      stat.match = match;
      stat.free  = (slot_in.repeats == 16'sd0);
      stat.fire  = 1'b0;
      unique case (op.mode)
         OP_PASS: begin
         end
         OP_INSERT: begin
            if (op.apply) begin
               slot_out.task_id   = op.task_id;
               slot_out.remaining = op.delay;
               slot_out.reload    = op.delay;
               slot_out.repeats   = op.repeat_count;
            end
         end
         OP_REMOVE: begin
            // apply arms the first match only
            if (op.apply && match) begin
               slot_out.repeats   = 16'sd0;
               slot_out.remaining = 31'd0;
            end
         end
         OP_TICK: begin
            if (slot_in.remaining != 31'd0) begin
               if (op.elapsed >= slot_in.remaining) begin
                  stat.fire        = 1'b1;
                  slot_out.repeats = rep_next;
                  slot_out.remaining = (rep_next != 16'sd0) ? slot_in.reload : 31'd0;
               end else begin
                  slot_out.remaining = rem_diff;
               end
            end
         end
      endcase
   end

endmodule

FILE: src/tmr_checker.sv
// Port checker for the timer table, bound to the top level.
`timescale 1ns / 1ps
module tmr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input tmr_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tmr_pkg::rsp_type rsp_data
);
   import tmr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response transaction changed");

   a_fire_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.fired && rsp_data.status))
      else $error("fire transaction carries table-full status");

   a_insert_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.fired |-> rsp_data.last && (rsp_data.fired_task == 8'd0))
      else $error("insert response not last or carries a task id");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.kind != KindNone) |=> req_stall)
      else $error("request accepted while previous transaction in progress");

endmodule

bind multi_slot_periodic_timer tmr_checker u_tmr_checker (.*);
